// File: rtl/core/utf8_stream_validator_core_defines.svh
// Assertion macros shared by the checker of the UTF-8 stream validator.
`ifndef UTF8_STREAM_VALIDATOR_CORE_DEFINES_SVH
`define UTF8_STREAM_VALIDATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define U8V_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define U8V_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/u8v_pkg.sv
// Types, constants, byte class table and DFA transition table of the UTF-8 validator.
package u8v_pkg;

  localparam int unsigned POS_WIDTH   = 31;
  localparam int unsigned NUM_STATES  = 9;
  localparam int unsigned NUM_CLASSES = 14;

  typedef logic [3:0] dfa_state_t;
  typedef logic [3:0] byte_class_t;

  localparam dfa_state_t S_ACC = 4'd0;
  localparam dfa_state_t S_ERR = 4'd8;

  localparam byte_class_t CLS_ASCII     = 4'd0;
  localparam byte_class_t CLS_FIRST_LEAD = 4'd4;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_TRUNC   = 2'd2
  } status_t;

  typedef struct packed {
    logic                 start_mark;
    logic                 error_now;
    logic                 done_res;
    status_t              status;
    logic [POS_WIDTH-1:0] error_pos;
  } u8v_result_t;

  localparam dfa_state_t TRANS [NUM_STATES][NUM_CLASSES] = '{
    '{4'd0, 4'd8, 4'd8, 4'd8, 4'd8, 4'd1, 4'd4, 4'd2, 4'd5, 4'd2, 4'd6, 4'd3, 4'd7, 4'd8},
    '{4'd8, 4'd0, 4'd0, 4'd0, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8},
    '{4'd8, 4'd1, 4'd1, 4'd1, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8},
    '{4'd8, 4'd2, 4'd2, 4'd2, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8},
    '{4'd8, 4'd8, 4'd8, 4'd1, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8},
    '{4'd8, 4'd1, 4'd1, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8},
    '{4'd8, 4'd8, 4'd2, 4'd2, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8},
    '{4'd8, 4'd2, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8},
    '{4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8}
  };

  // Sort a byte into one of the 14 classes the DFA steps over.
  function automatic byte_class_t byte_class(input logic [7:0] b);
    byte_class_t c;
    if      (b < 8'h80)  c = 4'd0;
    else if (b < 8'h90)  c = 4'd1;
    else if (b < 8'hA0)  c = 4'd2;
    else if (b < 8'hC0)  c = 4'd3;
    else if (b < 8'hC2)  c = 4'd4;
    else if (b < 8'hE0)  c = 4'd5;
    else if (b == 8'hE0) c = 4'd6;
    else if (b < 8'hED)  c = 4'd7;
    else if (b == 8'hED) c = 4'd8;
    else if (b < 8'hF0)  c = 4'd9;
    else if (b == 8'hF0) c = 4'd10;
    else if (b < 8'hF4)  c = 4'd11;
    else if (b == 8'hF4) c = 4'd12;
    else                 c = 4'd13;
    return c;
  endfunction

endpackage

// File: rtl/core/u8v_step.sv
// One DFA step: next string state and the result beat for one byte.
module u8v_step #(
  parameter int unsigned INDEX_WIDTH = 31
) (
  input  u8v_pkg::dfa_state_t   cur_state,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  input  logic                  error_seen,
  input  logic [INDEX_WIDTH-1:0] byte_index,
  input  logic [INDEX_WIDTH-1:0] sequence_start,
  input  logic [INDEX_WIDTH-1:0] first_error_pos,
  output u8v_pkg::dfa_state_t   state_nxt,
  output logic                  error_seen_nxt,
  output logic [INDEX_WIDTH-1:0] byte_index_nxt,
  output logic [INDEX_WIDTH-1:0] sequence_start_nxt,
  output logic [INDEX_WIDTH-1:0] first_error_pos_nxt,
  output u8v_pkg::u8v_result_t  result
);
  import u8v_pkg::*;

  dfa_state_t                     st_clamp;
  dfa_state_t                     st_step;
  byte_class_t                    cls;
  logic [INDEX_WIDTH-1:0]         seq_upd;
  logic [INDEX_WIDTH-1:0]         fep_upd;
  logic                           err_upd;
  dfa_state_t                     st_upd;
  logic [INDEX_WIDTH-1:0]         pos_idx;
  logic [INDEX_WIDTH+POS_WIDTH-1:0] pos_wide;
  status_t                        stat;

  always_comb begin
    cls      = byte_class(data_byte);
    st_clamp = (cur_state > S_ERR) ? S_ERR : cur_state;
    st_step  = TRANS[st_clamp][cls];

    seq_upd = sequence_start;
    fep_upd = first_error_pos;
    err_upd = error_seen;
    st_upd  = cur_state;
    result.start_mark = 1'b0;
    result.error_now  = 1'b0;

    if (!error_seen) begin
      // a new sequence opens whenever the DFA sits in accept
      if (st_clamp == S_ACC) begin
        seq_upd = byte_index;
      end
      st_upd = st_step;
      if (st_step == S_ERR) begin
        err_upd          = 1'b1;
        fep_upd          = seq_upd;
        result.error_now = 1'b1;
      end else if (cls == CLS_ASCII || cls >= CLS_FIRST_LEAD) begin
        result.start_mark = 1'b1;
      end
    end

    // end-of-string status
    stat    = STATUS_OK;
    pos_idx = '0;
    if (last_byte) begin
      if (err_upd) begin
        stat    = STATUS_INVALID;
        pos_idx = fep_upd;
      end else if (st_upd != S_ACC) begin
        stat    = STATUS_TRUNC;
        pos_idx = seq_upd;
      end
    end
    pos_wide         = {{POS_WIDTH{1'b0}}, pos_idx};
    result.done_res  = last_byte;
    result.status    = stat;
    result.error_pos = pos_wide[POS_WIDTH-1:0];

    // the last byte returns everything to reset for the next string
    if (last_byte) begin
      state_nxt           = S_ACC;
      error_seen_nxt      = 1'b0;
      byte_index_nxt      = '0;
      sequence_start_nxt  = '0;
      first_error_pos_nxt = '0;
    end else begin
      state_nxt           = st_upd;
      error_seen_nxt      = err_upd;
      byte_index_nxt      = (&byte_index) ? byte_index : byte_index + 1'b1;
      sequence_start_nxt  = seq_upd;
      first_error_pos_nxt = fep_upd;
    end
  end

endmodule

// File: rtl/core/utf8_stream_validator_core.sv
// Path: input register, then DFA step into the result register that drives the outputs.
// Throughput: one byte per cycle; the input register and the result register each advance
//   whenever the stage after them is empty or being drained, so stalls cost no bubbles.
// Reset: rst_n is synchronous, active low; it empties both registers and returns the DFA
//   to accept with all indexes at zero. A string's last byte resets DFA and indexes too.
// Top level of the strict UTF-8 byte stream validator.
module utf8_stream_validator_core #(
  parameter int unsigned INDEX_WIDTH = 31
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_data_byte,
  input  logic                              in_last_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_start_mark,
  output logic                              out_error_now,
  output logic                              out_done_res,
  output logic [1:0]                        out_status,
  output logic [u8v_pkg::POS_WIDTH-1:0]     out_error_pos
);
  import u8v_pkg::*;

  // Input register: one accepted beat waiting for the DFA.
  logic                   in_valid_r;
  logic [7:0]             in_byte_r;
  logic                   in_last_r;

  // String state, updated only when a beat moves into the result register.
  dfa_state_t             state_r;
  logic                   error_seen_r;
  logic [INDEX_WIDTH-1:0] byte_index_r;
  logic [INDEX_WIDTH-1:0] sequence_start_r;
  logic [INDEX_WIDTH-1:0] first_error_pos_r;

  dfa_state_t             state_nxt;
  logic                   error_seen_nxt;
  logic [INDEX_WIDTH-1:0] byte_index_nxt;
  logic [INDEX_WIDTH-1:0] sequence_start_nxt;
  logic [INDEX_WIDTH-1:0] first_error_pos_nxt;

  // Result register.
  logic                   out_valid_r;
  u8v_result_t            res_r;
  u8v_result_t            res_nxt;

  logic                   step_go;  // beat moves from input register to result register
  logic                   in_take;

  // The result register frees up when it is empty or its beat leaves this cycle;
  // the input register frees up when it is empty or its beat steps forward.
  assign step_go  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || step_go;
  assign in_take  = in_valid && in_ready;

  u8v_step #(
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_step (
    .cur_state           (state_r),
    .data_byte           (in_byte_r),
    .last_byte           (in_last_r),
    .error_seen          (error_seen_r),
    .byte_index          (byte_index_r),
    .sequence_start      (sequence_start_r),
    .first_error_pos     (first_error_pos_r),
    .state_nxt           (state_nxt),
    .error_seen_nxt      (error_seen_nxt),
    .byte_index_nxt      (byte_index_nxt),
    .sequence_start_nxt  (sequence_start_nxt),
    .first_error_pos_nxt (first_error_pos_nxt),
    .result              (res_nxt)
  );

  // Input register: valid bit under reset, payload loads on every accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_data_byte;
      in_last_r <= in_last_byte;
    end
  end

  // String state: advance only on a step, hold through stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_ACC;
      error_seen_r      <= 1'b0;
      byte_index_r      <= '0;
      sequence_start_r  <= '0;
      first_error_pos_r <= '0;
    end else if (step_go) begin
      state_r           <= state_nxt;
      error_seen_r      <= error_seen_nxt;
      byte_index_r      <= byte_index_nxt;
      sequence_start_r  <= sequence_start_nxt;
      first_error_pos_r <= first_error_pos_nxt;
    end
  end

  // Result register: fill on a step, drop the valid once the beat is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_start_mark = res_r.start_mark;
  assign out_error_now  = res_r.error_now;
  assign out_done_res   = res_r.done_res;
  assign out_status     = res_r.status;
  assign out_error_pos  = res_r.error_pos;

endmodule

// File: rtl/core/u8v_checker.sv
// Port-level assertions for the UTF-8 stream validator, bound to the top level.
`include "utf8_stream_validator_core_defines.svh"

module u8v_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_start_mark,
  input logic                          out_error_now,
  input logic                          out_done_res,
  input logic [1:0]                    out_status,
  input logic [u8v_pkg::POS_WIDTH-1:0] out_error_pos
);
  import u8v_pkg::*;

  // Status and position stay zero except on a string's final beat with a problem.
  `U8V_ASSERT_SAME(a_quiet_midstring, clk, rst_n,
    out_valid && (!out_done_res || out_status == STATUS_OK),
    out_error_pos == '0 && (out_done_res || out_status == STATUS_OK),
    "status or position set outside a failing last beat")

  // An error found on the last byte must report invalid on the same beat.
  `U8V_ASSERT_SAME(a_err_on_last, clk, rst_n,
    out_valid && out_error_now && out_done_res,
    out_status == STATUS_INVALID,
    "error on last byte without invalid status")

  // A byte that errors never carries a start mark, and status 3 is never used.
  `U8V_ASSERT_SAME(a_err_no_mark, clk, rst_n,
    out_valid,
    !(out_error_now && out_start_mark) && out_status != 2'd3,
    "errored byte marked or unused status code")

  // A stalled result beat holds.
  `U8V_ASSERT_NEXT(a_out_hold, clk, rst_n,
    out_valid && !out_ready,
    out_valid && $stable(out_status) && $stable(out_error_pos) && $stable(out_start_mark),
    "result beat changed while stalled")

endmodule

bind utf8_stream_validator_core u8v_checker u_u8v_checker (.*);
